// ===== design/irup_pkg.sv =====
package irup_pkg;

    // Default limits for one reply.
    localparam int MAX_NAME_CHARS_DEF  = 10;
    localparam int MAX_REPLY_BYTES_DEF = 128;

    // Result queue sizing. The depth is a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Result kinds.
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       final_byte;
    } irup_reply_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
        logic       ident_valid;
        logic       run_end;
    } irup_result_t;

    // Results produced by one byte, in delivery order. The count is zero, one or two.
    typedef struct packed {
        logic [1:0]   cnt;
        irup_result_t first;
        irup_result_t second;
    } irup_push_t;

endpackage

// ===== design/irup_parse.sv =====
module irup_parse
    import irup_pkg::*;
#(
    parameter int MAX_NAME_CHARS  = MAX_NAME_CHARS_DEF,
    parameter int MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  irup_reply_t reply,
    output irup_push_t  push
);

    localparam logic [2:0] ST_REMOTE  = 3'd0;
    localparam logic [2:0] ST_LOCAL   = 3'd1;
    localparam logic [2:0] ST_KEYWORD = 3'd2;
    localparam logic [2:0] ST_OSTYPE  = 3'd3;
    localparam logic [2:0] ST_SKIP    = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;
    localparam logic [2:0] ST_FAIL    = 3'd7;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_OVER   = 2'd3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_U       = 8'h55;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    localparam logic [2:0] KEYWORD_LEN = 3'd6;

    typedef struct packed {
        logic [2:0] stage;
        logic [1:0] phase;
        logic       remote_nz;
        logic       local_nz;
        logic [2:0] kw_prog;
        logic       kw_found;
        logic [7:0] bytes_taken;
        logic [6:0] name_room;
        logic       reply_ended;
    } irup_state_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       nz;
    } irup_scan_t;

    localparam irup_state_t STATE_INIT = '{
        stage:       ST_REMOTE,
        phase:       PH_SPACE,
        remote_nz:   1'b0,
        local_nz:    1'b0,
        kw_prog:     3'd0,
        kw_found:    1'b0,
        bytes_taken: 8'd0,
        name_room:   7'(MAX_NAME_CHARS),
        reply_ended: 1'b0
    };

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Letters of the USERID keyword, by position.
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h55;
            3'd1:    ch = 8'h53;
            3'd2:    ch = 8'h45;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h49;
            3'd5:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // One step of the atoi-style port scanner.
    function automatic irup_scan_t port_scan(input logic [1:0] phase, input logic [7:0] c);
        irup_scan_t r;
        logic       digit;
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.phase = phase;
        r.nz    = 1'b0;
        case (phase)
            PH_SPACE, PH_SIGN, PH_DIGITS:
            begin
                if ((phase == PH_SPACE) && is_white(c))
                begin
                    r.phase = PH_SPACE;
                end
                else if ((phase == PH_SPACE) && ((c == CH_PLUS) || (c == CH_MINUS)))
                begin
                    r.phase = PH_SIGN;
                end
                else if (digit)
                begin
                    r.phase = PH_DIGITS;
                    r.nz    = (c != CH_ZERO);
                end
                else
                begin
                    r.phase = PH_OVER;
                end
            end
            default:
            begin
                r.phase = PH_OVER;
            end
        endcase
        return r;
    endfunction

    irup_state_t  state_reg;
    irup_state_t  state_next;
    irup_state_t  step_state;
    irup_scan_t   scan;
    logic [7:0]   c;
    logic         fin;
    logic         emit;
    logic         verdict;
    logic [2:0]   kw_step;
    logic [6:0]   room_dec;
    irup_result_t name_res;
    irup_result_t verdict_res;

    assign c   = reply.reply_byte;
    assign fin = reply.final_byte;

    always_comb
    begin
        step_state = state_reg;
        emit       = 1'b0;
        scan       = port_scan(state_reg.phase, c);
        room_dec   = (state_reg.name_room != 7'd0) ? (state_reg.name_room - 7'd1)
                                                   : state_reg.name_room;

        // Keyword matcher: extend the match or restart it on a fresh 'U'.
        if ((state_reg.kw_prog < KEYWORD_LEN) && (c == keyword_char(state_reg.kw_prog)))
        begin
            kw_step = state_reg.kw_prog + 3'd1;
        end
        else
        begin
            kw_step = (c == CH_U) ? 3'd1 : 3'd0;
        end

        if (!state_reg.reply_ended)
        begin
            if (state_reg.bytes_taken >= 8'(MAX_REPLY_BYTES))
            begin
                step_state.reply_ended = 1'b1;
            end
            else
            begin
                if (state_reg.bytes_taken != 8'hFF)
                begin
                    step_state.bytes_taken = state_reg.bytes_taken + 8'd1;
                end
                if (c == CH_NUL)
                begin
                    step_state.reply_ended = 1'b1;
                end
                else
                begin
                    case (state_reg.stage)
                        ST_REMOTE:
                        begin
                            if (c == CH_COMMA)
                            begin
                                step_state.stage = ST_LOCAL;
                                step_state.phase = PH_SPACE;
                            end
                            else if (c == CH_COLON)
                            begin
                                step_state.stage = ST_FAIL;
                            end
                            else
                            begin
                                step_state.phase     = scan.phase;
                                step_state.remote_nz = state_reg.remote_nz | scan.nz;
                            end
                        end
                        ST_LOCAL:
                        begin
                            if (c == CH_COLON)
                            begin
                                if (state_reg.remote_nz && state_reg.local_nz)
                                begin
                                    step_state.stage   = ST_KEYWORD;
                                    step_state.kw_prog = 3'd0;
                                end
                                else
                                begin
                                    step_state.stage = ST_FAIL;
                                end
                            end
                            else
                            begin
                                step_state.phase    = scan.phase;
                                step_state.local_nz = state_reg.local_nz | scan.nz;
                            end
                        end
                        ST_KEYWORD:
                        begin
                            if (c == CH_COLON)
                            begin
                                step_state.stage = state_reg.kw_found ? ST_OSTYPE : ST_FAIL;
                            end
                            else if (kw_step >= KEYWORD_LEN)
                            begin
                                step_state.kw_found = 1'b1;
                                step_state.kw_prog  = 3'd0;
                            end
                            else
                            begin
                                step_state.kw_prog = kw_step;
                            end
                        end
                        ST_OSTYPE:
                        begin
                            if (c == CH_COLON)
                            begin
                                step_state.stage = ST_SKIP;
                            end
                        end
                        ST_SKIP, ST_EMIT:
                        begin
                            // Leading '~' and '^' are dropped only before any other byte of the name field.
                            if (!((state_reg.stage == ST_SKIP) &&
                                  ((c == CH_TILDE) || (c == CH_CARET))))
                            begin
                                step_state.stage = ST_EMIT;
                                if (c == CH_AT)
                                begin
                                    step_state.stage = ST_DONE;
                                end
                                else if (!(is_white(c) || (c == CH_COLON) ||
                                           (c == CH_BRACKET)))
                                begin
                                    emit                 = 1'b1;
                                    step_state.name_room = room_dec;
                                    if (room_dec == 7'd0)
                                    begin
                                        step_state.stage = ST_DONE;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        verdict    = step_state.stage inside {ST_SKIP, ST_EMIT, ST_DONE};
        state_next = fin ? STATE_INIT : step_state;
    end

    always_comb
    begin
        name_res.kind        = KIND_NAME;
        name_res.name_char   = c;
        name_res.ident_valid = 1'b0;
        name_res.run_end     = !fin;

        verdict_res.kind        = KIND_VERDICT;
        verdict_res.name_char   = 8'd0;
        verdict_res.ident_valid = verdict;
        verdict_res.run_end     = 1'b1;

        push.first  = emit ? name_res : verdict_res;
        push.second = verdict_res;
        push.cnt    = fire ? ({1'b0, emit} + {1'b0, fin}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // A final byte always leaves the parser ready for a new reply.
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin |=> (state_reg.stage == ST_REMOTE) && (state_reg.bytes_taken == 8'd0))
        else $error("parser state not restarted after final byte");

    // Name bytes come only out of the name stages of a live reply.
    a_emit_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |-> !state_reg.reply_ended &&
                         ((state_reg.stage == ST_SKIP) || (state_reg.stage == ST_EMIT)))
        else $error("name byte emitted outside the name field");

    // The name budget is never exceeded within one reply.
    a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.name_room <= 7'(MAX_NAME_CHARS))
        else $error("name room above its limit");

endmodule

// ===== design/irup_result_queue.sv =====
module irup_result_queue
    import irup_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  irup_push_t   push,
    output logic         room,
    output logic         result_valid,
    input  logic         result_stall,
    output irup_result_t result
);

    irup_result_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   pop;

    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // Room for the worst case of two results, regardless of a pop this cycle.
    assign room         = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + QUEUE_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push.cnt) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QUEUE_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("results pushed without room");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == QUEUE_PTR_W'(count_reg))
        else $error("result queue pointers and count disagree");

endmodule

// ===== design/ident_reply_username_parser.sv =====
// Path: an accepted request is held in the input register, parsed once the result queue
// has room, and its results are written to the result queue, from which they are offered.
// Throughput: one request per cycle while reply_stall is low; a request that yields a name
// byte and a verdict puts two results into the four-entry result queue.
// Reset: rst_n is asynchronous and active low; it empties the input register and the
// result queue and returns the parser to the start of a reply.
module ident_reply_username_parser
    import irup_pkg::*;
#(
    parameter int MAX_NAME_CHARS  = MAX_NAME_CHARS_DEF,
    parameter int MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         reply_valid,
    output logic         reply_stall,
    input  irup_reply_t  reply,
    output logic         result_valid,
    input  logic         result_stall,
    output irup_result_t result
);

    // The input register holds one request. It is parsed once it is held there and
    // the result queue can absorb the worst case of two results.
    logic        hold_vld_reg;
    logic        hold_vld_next;
    irup_reply_t hold_reg;
    logic        room;
    logic        fire;
    logic        take;
    irup_push_t  push;

    assign fire        = hold_vld_reg && room;
    // Stall only while the held request cannot move on.
    assign reply_stall = hold_vld_reg && !room;
    assign take        = reply_valid && !reply_stall;

    always_comb
    begin
        if (take)
        begin
            hold_vld_next = 1'b1;
        end
        else if (fire)
        begin
            hold_vld_next = 1'b0;
        end
        else
        begin
            hold_vld_next = hold_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    // Payload needs no reset; it is only used while the valid flag is set.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= reply;
        end
    end

    // The parser keeps the per-reply state and turns each byte into its results.
    irup_parse #(
        .MAX_NAME_CHARS  (MAX_NAME_CHARS),
        .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .reply (hold_reg),
        .push  (push)
    );

    // The result queue decouples the parser from a stalled result port.
    irup_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
